### rtl/tct_pkg.sv
`timescale 1ns / 1ps

package tct_pkg;

   localparam int COORD_WIDTH_DEF = 8;

   localparam int CFG_W   = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COLS   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ROWS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAB_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LF_CLR_COL = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CR_ADV_ROW = 3'd4;

   localparam logic [7:0] MAX_COLS_RST  = 8'd80;
   localparam logic [7:0] MAX_ROWS_RST  = 8'd24;
   localparam logic [7:0] TAB_WIDTH_RST = 8'd8;

   localparam logic [7:0] CH_BS        = 8'h08;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_LF        = 8'h0A;
   localparam logic [7:0] CH_FF        = 8'h0C;
   localparam logic [7:0] CH_CR        = 8'h0D;
   localparam logic [7:0] CH_PRINT_LO  = 8'h20;
   localparam logic [7:0] CH_PRINT_HI  = 8'h7E;

   typedef enum logic [1:0] {
      OP_CHAR    = 2'd0,
      OP_LOCATE  = 2'd1,
      OP_SAVE    = 2'd2,
      OP_RESTORE = 2'd3
   } tct_op_type;

   // remainder unit: dividend covers a 16-bit locate value and col + tab - 1
   localparam int DIV_W       = 20;
   localparam int DIV_RADIX   = 4;
   localparam int DIV_CYCLES  = DIV_W / DIV_RADIX;
   localparam int DIV_CNT_W   = $clog2(DIV_CYCLES + 1);
   localparam int DVS_W       = 9;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [DVS_W-1:0]  divisor;
   } tct_div_req_type;

   typedef struct packed {
      logic              done;
      logic [DVS_W-1:0]  remainder;
   } tct_div_rsp_type;

endpackage

### rtl/tct_rem_unit.sv
`timescale 1ns / 1ps

module tct_rem_unit import tct_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  tct_div_req_type div_req,
   output tct_div_rsp_type div_rsp
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     dvd_ff;
   logic [DVS_W-1:0]     dvs_ff;
   logic [DVS_W-1:0]     rem_ff;
   logic [DVS_W-1:0]     rem_in;
   logic [DVS_W:0]       trial;

   // restoring remainder, DIV_RADIX dividend bits per cycle
   always_comb begin
      rem_in = rem_ff;
      trial  = '0;
      for (int i = 0; i < DIV_RADIX; i++) begin
         trial = {rem_in, dvd_ff[DIV_W-1-i]};
         if (trial >= {1'b0, dvs_ff}) begin
            trial = trial - {1'b0, dvs_ff};
         end
         rem_in = trial[DVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_CYCLES);
            dvd_ff  <= div_req.dividend;
            dvs_ff  <= div_req.divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            dvd_ff <= dvd_ff << DIV_RADIX;
            cnt_ff <= cnt_ff - DIV_CNT_W'(1);
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

### rtl/terminal_cursor_tracker_unit.sv
`timescale 1ns / 1ps

// Cursor tracker for a VT100-style terminal. Each req_ transaction (character,
// locate, save or restore) yields one rsp_ transaction carrying the cursor
// column and row after it. Characters other than TAB, save, restore and a
// locate with a zero coordinate pass through S_EXEC and S_OUT; TAB adds S_TAB
// and a locate S_LROW and S_LCOL, waiting on the shared remainder unit, which
// retires 4 bits of a 20-bit dividend per cycle and is used once for the tab
// stop and twice (row, then column) for a locate. req_ready is high only while
// the tracker is idle; a finished response waits in the output register
// without blocking the next request. Configuration writes through csr_ take
// effect at once and are meant for idle periods.

module terminal_cursor_tracker_unit import tct_pkg::*; #(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_opcode,
   input  logic [7:0]           req_character,
   input  logic [15:0]          req_locate_row,
   input  logic [15:0]          req_locate_col,

   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [7:0]           rsp_cursor_col,
   output logic [7:0]           rsp_cursor_row,

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int CW    = COORD_WIDTH;
   localparam int CMP_W = (COORD_WIDTH + 1 > 9) ? COORD_WIDTH + 1 : 9;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_TAB,
      S_LROW,
      S_LCOL,
      S_OUT
   } state_type;

   // configuration
   logic [7:0] max_cols_ff;
   logic [7:0] max_rows_ff;
   logic [7:0] tab_width_ff;
   logic       lf_clr_col_ff;
   logic       cr_adv_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_cols_ff   <= MAX_COLS_RST;
         max_rows_ff   <= MAX_ROWS_RST;
         tab_width_ff  <= TAB_WIDTH_RST;
         lf_clr_col_ff <= 1'b1;
         cr_adv_row_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_COLS:   max_cols_ff   <= csr_wdata;
            CSR_MAX_ROWS:   max_rows_ff   <= csr_wdata;
            CSR_TAB_WIDTH:  tab_width_ff  <= csr_wdata;
            CSR_LF_CLR_COL: lf_clr_col_ff <= csr_wdata[0];
            CSR_CR_ADV_ROW: cr_adv_row_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   state_type   state_ff, state_in;
   tct_op_type  op_ff, op_in;
   logic [7:0]  char_ff, char_in;
   logic [15:0] lrow_ff, lrow_in;
   logic [15:0] lcol_ff, lcol_in;
   logic [CW-1:0] cur_col_ff, cur_col_in;
   logic [CW-1:0] cur_row_ff, cur_row_in;
   logic [CW-1:0] sav_col_ff, sav_col_in;
   logic [CW-1:0] sav_row_ff, sav_row_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  rsp_col_ff, rsp_col_in;
   logic [7:0]  rsp_row_ff, rsp_row_in;

   tct_div_req_type div_req;
   tct_div_rsp_type div_rsp;

   tct_rem_unit u_rem (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   logic [CMP_W-1:0] col_inc;
   logic [CMP_W-1:0] row_inc;
   logic [CMP_W-1:0] rows_ext;
   logic [CMP_W-1:0] cols_ext;
   logic [CW-1:0]    row_adv;
   logic [CW-1:0]    row_wrap;
   logic [7:0]       tab_eff;
   logic [DIV_W-1:0] tab_dvd;
   logic [DIV_W-1:0] tab_round;
   logic             loc_go;

   assign col_inc  = CMP_W'(cur_col_ff) + CMP_W'(1);
   assign row_inc  = CMP_W'(cur_row_ff) + CMP_W'(1);
   assign rows_ext = CMP_W'(max_rows_ff);
   assign cols_ext = CMP_W'(max_cols_ff);

   // LF/CR row advance, clamped to max_rows_ff - 1 (0 when max_rows_ff is 0)
   assign row_adv = (row_inc < rows_ext) ? CW'(row_inc) :
                    (max_rows_ff == 8'd0) ? '0 : CW'(max_rows_ff - 8'd1);
   // row step on column wrap
   assign row_wrap = (CMP_W'(cur_row_ff) < rows_ext) ? CW'(row_inc) : cur_row_ff;

   assign tab_eff   = (tab_width_ff == 8'd0) ? 8'd1 : tab_width_ff;
   assign tab_dvd   = DIV_W'(cur_col_ff) + DIV_W'(tab_eff) - DIV_W'(1);
   assign tab_round = tab_dvd - DIV_W'(div_rsp.remainder);
   assign loc_go    = (lrow_ff != 16'd0) && (lcol_ff != 16'd0);

   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = tab_dvd;
      div_req.divisor  = DVS_W'(tab_eff);
      case (state_ff)
         S_EXEC: begin
            if (op_ff == OP_CHAR && char_ff == CH_TAB) begin
               div_req.start = 1'b1;
            end else if (op_ff == OP_LOCATE && loc_go) begin
               div_req.start    = 1'b1;
               div_req.dividend = DIV_W'(lrow_ff);
               div_req.divisor  = DVS_W'(max_rows_ff) + DVS_W'(1);
            end
         end
         S_LROW: begin
            div_req.start    = div_rsp.done;
            div_req.dividend = DIV_W'(lcol_ff);
            div_req.divisor  = DVS_W'(max_cols_ff) + DVS_W'(1);
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      char_in      = char_ff;
      lrow_in      = lrow_ff;
      lcol_in      = lcol_ff;
      cur_col_in   = cur_col_ff;
      cur_row_in   = cur_row_ff;
      sav_col_in   = sav_col_ff;
      sav_row_in   = sav_row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_col_in   = rsp_col_ff;
      rsp_row_in   = rsp_row_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in    = tct_op_type'(req_opcode);
               char_in  = req_character;
               lrow_in  = req_locate_row;
               lcol_in  = req_locate_col;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_OUT;
            case (op_ff)
               OP_CHAR: begin
                  case (char_ff)
                     CH_BS: begin
                        if (cur_col_ff <= CW'(1)) begin
                           cur_col_in = CW'(max_cols_ff);
                           if (cur_row_ff > CW'(1)) begin
                              cur_row_in = cur_row_ff - CW'(1);
                           end
                        end else begin
                           cur_col_in = cur_col_ff - CW'(1);
                        end
                     end
                     CH_TAB: state_in = S_TAB;
                     CH_LF: begin
                        if (lf_clr_col_ff) begin
                           cur_col_in = '0;
                        end
                        cur_row_in = row_adv;
                     end
                     CH_FF: begin
                        cur_col_in = '0;
                        cur_row_in = '0;
                     end
                     CH_CR: begin
                        cur_col_in = '0;
                        if (cr_adv_row_ff) begin
                           cur_row_in = row_adv;
                        end
                     end
                     default: begin
                        if (char_ff >= CH_PRINT_LO && char_ff <= CH_PRINT_HI) begin
                           if (col_inc >= cols_ext) begin
                              cur_col_in = CW'(1);
                              cur_row_in = row_wrap;
                           end else begin
                              cur_col_in = CW'(col_inc);
                           end
                        end
                     end
                  endcase
               end
               OP_LOCATE: begin
                  if (loc_go) begin
                     state_in = S_LROW;
                  end
               end
               OP_SAVE: begin
                  sav_col_in = cur_col_ff;
                  sav_row_in = cur_row_ff;
               end
               default: begin
                  cur_col_in = sav_col_ff;
                  cur_row_in = sav_row_ff;
               end
            endcase
         end
         S_TAB: begin
            if (div_rsp.done) begin
               if (tab_round >= DIV_W'(max_cols_ff)) begin
                  cur_col_in = CW'(1);
                  cur_row_in = row_wrap;
               end else begin
                  cur_col_in = CW'(tab_round);
               end
               state_in = S_OUT;
            end
         end
         S_LROW: begin
            if (div_rsp.done) begin
               cur_row_in = CW'(div_rsp.remainder);
               state_in   = S_LCOL;
            end
         end
         S_LCOL: begin
            if (div_rsp.done) begin
               cur_col_in = CW'(div_rsp.remainder);
               state_in   = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = 8'(cur_col_ff);
               rsp_row_in   = 8'(cur_row_ff);
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_col_ff   <= '0;
         cur_row_ff   <= '0;
         sav_col_ff   <= '0;
         sav_row_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_col_ff   <= cur_col_in;
         cur_row_ff   <= cur_row_in;
         sav_col_ff   <= sav_col_in;
         sav_row_ff   <= sav_row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff      <= op_in;
      char_ff    <= char_in;
      lrow_ff    <= lrow_in;
      lcol_ff    <= lcol_in;
      rsp_col_ff <= rsp_col_in;
      rsp_row_ff <= rsp_row_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;

endmodule

### rtl/tct_checker.sv
`timescale 1ns / 1ps

module tct_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_cursor_col,
   input logic [7:0] rsp_cursor_row
);

   // a pending response holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_cursor_col) && $stable(rsp_cursor_row))
      else $error("response changed while stalled");

   // one transaction in flight at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready stayed high after accept");

   // no response can appear the cycle after an accept
   a_no_early_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response too early after accept");

   // a new response is posted only as the tracker returns to idle
   a_rsp_at_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("response posted while busy");

endmodule

bind terminal_cursor_tracker_unit tct_checker u_tct_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_cursor_col (rsp_cursor_col),
   .rsp_cursor_row (rsp_cursor_row)
);
